// File: rtl/lcbe_pkg.sv
package lcbe_pkg;

    // frame buffer geometry
    localparam int BUF_DEPTH = 256;
    localparam int BUF_AW    = $clog2(BUF_DEPTH);

    // stream word layout
    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 8;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_HIGH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_HIGH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_PERIOD = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_LOW  = 2'd3;

    localparam logic [7:0]  ZERO_HIGH_RST  = 8'd4;
    localparam logic [7:0]  ONE_HIGH_RST   = 8'd16;
    localparam logic [7:0]  BIT_PERIOD_RST = 8'd20;
    localparam logic [15:0] RESET_LOW_RST  = 16'd800;

    // item kinds carried in tuser
    localparam logic [S_TUSER_W-1:0] KIND_TICK  = 2'd0;
    localparam logic [S_TUSER_W-1:0] KIND_WRITE = 2'd1;
    localparam logic [S_TUSER_W-1:0] KIND_START = 2'd2;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_RESET,
        PH_DATA
    } phase_t;

endpackage

// File: rtl/led_chain_bit_encoder.sv
// result: the result word for an item is registered into the output buffer when the item is accepted
// throughput: one item per cycle; the two-word output buffer only drops s_tready
//   when both of its stages hold words that the sink has not taken
// reset: rst_n clears the phase, counters, line level and output buffer and restores
//   the timing registers; frame buffer contents stay undefined until written
module led_chain_bit_encoder (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // byte_index[7:0], byte_value[15:8], led_count[22:16], zero pad[23]
    input  logic [lcbe_pkg::S_TDATA_W-1:0]   s_tdata,
    // kind[1:0]
    input  logic [lcbe_pkg::S_TUSER_W-1:0]   s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // line_level[0], ready_res[1], zero pad[7:2]
    output logic [lcbe_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                             cfg_we,
    input  logic [lcbe_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lcbe_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    import lcbe_pkg::*;

    // input word fields
    logic [1:0] in_kind;
    logic [7:0] in_idx;
    logic [7:0] in_val;
    logic [6:0] in_leds;

    assign in_kind = s_tuser;
    assign in_idx  = s_tdata[7:0];
    assign in_val  = s_tdata[15:8];
    assign in_leds = s_tdata[22:16];

    logic accept;
    assign accept = s_tvalid && s_tready;

    // timing registers
    logic [7:0]  zero_high_reg;
    logic [7:0]  one_high_reg;
    logic [7:0]  bit_period_reg;
    logic [15:0] reset_low_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_high_reg  <= ZERO_HIGH_RST;
            one_high_reg   <= ONE_HIGH_RST;
            bit_period_reg <= BIT_PERIOD_RST;
            reset_low_reg  <= RESET_LOW_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ZERO_HIGH:  zero_high_reg  <= cfg_wdata[7:0];
                CFG_ONE_HIGH:   one_high_reg   <= cfg_wdata[7:0];
                CFG_BIT_PERIOD: bit_period_reg <= cfg_wdata[7:0];
                CFG_RESET_LOW:  reset_low_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // encoder state
    phase_t      phase_reg, phase_next;
    logic [15:0] tick_reg, tick_next;
    logic [7:0]  byte_pos_reg, byte_pos_next;
    logic [2:0]  bit_pos_reg, bit_pos_next;
    logic [7:0]  frame_bytes_reg, frame_bytes_next;
    logic        line_reg, line_next;

    logic [7:0] buf_rd_data;
    logic       buf_we;

    // read address follows the next byte position, so the read word always
    // matches the byte the state points at
    lcbe_ram #(
        .WIDTH (8),
        .DEPTH (BUF_DEPTH)
    ) u_frame_buf (
        .clk     (clk),
        .wr_en   (buf_we),
        .wr_addr (BUF_AW'(in_idx)),
        .wr_data (in_val),
        .rd_addr (BUF_AW'(byte_pos_next)),
        .rd_data (buf_rd_data)
    );

    logic        is_idle;
    logic [15:0] tick_inc;
    logic [7:0]  byte_inc;
    logic        cur_bit;
    logic [7:0]  high_time;
    logic        reset_done;
    logic        cell_end;
    logic        last_bit;
    logic        frame_end;
    logic        start_ok;
    logic [8:0]  frame_len;

    assign is_idle    = (phase_reg == PH_IDLE);
    assign tick_inc   = tick_reg + 16'd1;
    assign byte_inc   = byte_pos_reg + 8'd1;
    assign cur_bit    = buf_rd_data[~bit_pos_reg];
    assign high_time  = cur_bit ? one_high_reg : zero_high_reg;
    assign reset_done = (tick_inc >= reset_low_reg);
    assign cell_end   = (tick_inc >= {8'd0, bit_period_reg});
    assign last_bit   = (bit_pos_reg == 3'd7);
    assign frame_end  = (byte_inc >= frame_bytes_reg);
    assign start_ok   = is_idle && (in_leds != 7'd0);
    // three bytes per led; the stored frame length saturates at 255
    assign frame_len  = {2'b00, in_leds} + {1'b0, in_leds, 1'b0};
    assign buf_we     = accept && (in_kind == KIND_WRITE) && is_idle;

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            case (in_kind)
                KIND_TICK:
                begin
                    case (phase_reg)
                        PH_RESET:
                        begin
                            if (reset_done)
                            begin
                                phase_next = PH_DATA;
                            end
                        end
                        PH_DATA:
                        begin
                            if (cell_end && last_bit && frame_end)
                            begin
                                phase_next = PH_IDLE;
                            end
                        end
                        default: ;
                    endcase
                end
                KIND_START:
                begin
                    if (start_ok)
                    begin
                        phase_next = PH_RESET;
                    end
                end
                default: ;
            endcase
        end
    end

    // counters and line level
    always_comb
    begin
        tick_next        = tick_reg;
        byte_pos_next    = byte_pos_reg;
        bit_pos_next     = bit_pos_reg;
        frame_bytes_next = frame_bytes_reg;
        line_next        = line_reg;
        if (accept)
        begin
            case (in_kind)
                KIND_TICK:
                begin
                    case (phase_reg)
                        PH_RESET:
                        begin
                            line_next = 1'b0;
                            if (reset_done)
                            begin
                                tick_next     = 16'd0;
                                byte_pos_next = 8'd0;
                                bit_pos_next  = 3'd0;
                            end
                            else
                            begin
                                tick_next = tick_inc;
                            end
                        end
                        PH_DATA:
                        begin
                            line_next = (tick_reg < {8'd0, high_time});
                            if (cell_end)
                            begin
                                tick_next = 16'd0;
                                if (last_bit)
                                begin
                                    bit_pos_next  = 3'd0;
                                    byte_pos_next = byte_inc;
                                    if (frame_end)
                                    begin
                                        line_next = 1'b0;
                                    end
                                end
                                else
                                begin
                                    bit_pos_next = bit_pos_reg + 3'd1;
                                end
                            end
                            else
                            begin
                                tick_next = tick_inc;
                            end
                        end
                        default:
                        begin
                            line_next = 1'b0;
                        end
                    endcase
                end
                KIND_START:
                begin
                    if (start_ok)
                    begin
                        frame_bytes_next = frame_len[8] ? 8'hFF : frame_len[7:0];
                        byte_pos_next    = 8'd0;
                        bit_pos_next     = 3'd0;
                        tick_next        = 16'd0;
                        line_next        = 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            tick_reg        <= 16'd0;
            byte_pos_reg    <= 8'd0;
            bit_pos_reg     <= 3'd0;
            frame_bytes_reg <= 8'd0;
            line_reg        <= 1'b0;
        end
        else
        begin
            phase_reg       <= phase_next;
            tick_reg        <= tick_next;
            byte_pos_reg    <= byte_pos_next;
            bit_pos_reg     <= bit_pos_next;
            frame_bytes_reg <= frame_bytes_next;
            line_reg        <= line_next;
        end
    end

    // two-word output buffer: main stage plus skid stage
    logic [1:0] result_word;
    logic       out_valid_reg, out_valid_next;
    logic       skid_valid_reg, skid_valid_next;
    logic [1:0] out_data_reg, out_data_next;
    logic [1:0] skid_data_reg, skid_data_next;
    logic       pop;

    assign result_word = {phase_next == PH_IDLE, line_next};
    assign pop         = out_valid_reg && m_tready;
    assign s_tready    = !skid_valid_reg;
    assign m_tvalid    = out_valid_reg;
    assign m_tdata     = {{(M_TDATA_W - 2){1'b0}}, out_data_reg};

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (accept)
        begin
            if (!out_valid_reg || pop)
            begin
                out_data_next  = result_word;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_data_next  = result_word;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    // the skid stage only fills behind a held main stage
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word without main word");

    // the line can only be high while bits are being sent
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_DATA) |-> !line_reg)
        else $error("line high outside data phase");

    // an accepted start from idle with a nonzero led count always opens the reset phase
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_idle && (in_kind == KIND_START) && (in_leds != 7'd0))
            |=> (phase_reg == PH_RESET))
        else $error("start did not enter reset phase");

    // a frame in flight always has bytes to send
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DATA) |-> (frame_bytes_reg != 8'd0))
        else $error("data phase with empty frame");

endmodule

// File: rtl/lcbe_ram.sv
module lcbe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// File: tb/sv/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lcbe_pkg::*;

    // kind three carries no operation, the block accepts it and leaves its state unchanged
    localparam logic [S_TUSER_W-1:0] KIND_SPARE = 2'd3;
    localparam int N_SETS = 10;
    localparam int PHASE_ITEMS = 70;
    localparam int REPORT_MAX = 10;
    localparam int FILL_BYTES = 16;

    typedef struct packed {
        logic line;
        logic ready;
    } line_word_t;

    typedef struct packed {
        logic [S_TUSER_W-1:0] kind;
        logic [7:0]           idx;
        logic [7:0]           val;
        logic [6:0]           leds;
        logic [15:0]          reps;
        logic                 typed;
        line_word_t           want;
    } stim_row_t;

    typedef struct packed {
        logic [7:0]  zero_hi;
        logic [7:0]  one_hi;
        logic [7:0]  period;
        logic [15:0] reset_lo;
        logic [6:0]  leds_max;
    } timing_set_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic [S_TUSER_W-1:0]  s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    led_chain_bit_encoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #1_000_000;
        $display("tb_top: done, errors");
        $finish;
    end

    // encoder state as the block should hold it
    phase_t      enc_phase = PH_IDLE;
    logic [15:0] enc_ticks = '0;
    logic [7:0]  enc_byte = '0;
    logic [2:0]  enc_bit = '0;
    logic [7:0]  enc_frame_bytes = '0;
    logic        enc_line = 1'b0;
    logic [7:0]  pixel_mem [BUF_DEPTH];
    logic [7:0]  reg_zero_hi = ZERO_HIGH_RST;
    logic [7:0]  reg_one_hi = ONE_HIGH_RST;
    logic [7:0]  reg_period = BIT_PERIOD_RST;
    logic [15:0] reg_reset_lo = RESET_LOW_RST;

    line_word_t line_expect_q [$];
    int         err_count = 0;
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;

    function void encoder_tick();
        logic [7:0] hi;
        case (enc_phase)
            PH_RESET:
            begin
                enc_line = 1'b0;
                enc_ticks = enc_ticks + 16'd1;
                if (enc_ticks >= reg_reset_lo)
                begin
                    enc_phase = PH_DATA;
                    enc_ticks = '0;
                    enc_byte = '0;
                    enc_bit = '0;
                end
            end
            PH_DATA:
            begin
                // msb of each byte goes out first
                hi = pixel_mem[enc_byte][3'd7 - enc_bit] ? reg_one_hi : reg_zero_hi;
                enc_line = (enc_ticks < {8'd0, hi});
                enc_ticks = enc_ticks + 16'd1;
                if (enc_ticks >= {8'd0, reg_period})
                begin
                    enc_ticks = '0;
                    if (enc_bit == 3'd7)
                    begin
                        enc_bit = '0;
                        enc_byte = enc_byte + 8'd1;
                        if (enc_byte >= enc_frame_bytes)
                        begin
                            enc_phase = PH_IDLE;
                            enc_line = 1'b0;
                        end
                    end
                    else
                    begin
                        enc_bit = enc_bit + 3'd1;
                    end
                end
            end
            default: enc_line = 1'b0;
        endcase
    endfunction

    function line_word_t encoder_advance(input logic [S_TUSER_W-1:0] kind,
                                         input logic [7:0] idx, input logic [7:0] val,
                                         input logic [6:0] leds);
        logic [8:0] n;
        logic       idle;
        idle = (enc_phase == PH_IDLE);
        n = {2'b00, leds} * 9'd3;
        case (kind)
            KIND_TICK: encoder_tick();
            KIND_WRITE:
            begin
                if (idle)
                    pixel_mem[idx] = val;
            end
            KIND_START:
            begin
                if (idle && leds != 7'd0)
                begin
                    enc_frame_bytes = (n > 9'd255) ? 8'd255 : n[7:0];
                    enc_byte = '0;
                    enc_bit = '0;
                    enc_ticks = '0;
                    enc_line = 1'b0;
                    enc_phase = PH_RESET;
                end
            end
            default: ;
        endcase
        return '{line: enc_line, ready: (enc_phase == PH_IDLE)};
    endfunction

    function void encoder_set_reg(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_ZERO_HIGH:  reg_zero_hi = data[7:0];
            CFG_ONE_HIGH:   reg_one_hi = data[7:0];
            CFG_BIT_PERIOD: reg_period = data[7:0];
            CFG_RESET_LOW:  reg_reset_lo = data;
            default: ;
        endcase
    endfunction

    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin : check_results
        line_word_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (line_expect_q.size() == 0)
            begin
                err_count++;
                if (err_count <= REPORT_MAX)
                    $display("%0t: result word %h with nothing expected", $time, m_tdata);
            end
            else
            begin
                want = line_expect_q.pop_front();
                if (m_tdata[0] !== want.line || m_tdata[1] !== want.ready)
                begin
                    err_count++;
                    if (err_count <= REPORT_MAX)
                        $display("%0t: line/ready expected %b/%b, got %b/%b", $time,
                                 want.line, want.ready, m_tdata[0], m_tdata[1]);
                end
            end
        end
    end

    function void set_idle_mode(input int mode);
        case (mode % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
            default: begin send_idle_pct = 24; recv_stall_pct = 24; end
        endcase
    endfunction

    task send_item(input logic [S_TUSER_W-1:0] kind, input logic [7:0] idx,
                   input logic [7:0] val, input logic [6:0] leds, output line_word_t got);
        @(negedge clk);
        while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {1'b0, leds, val, idx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        got = encoder_advance(kind, idx, val, leds);
    endtask

    task issue(input logic [S_TUSER_W-1:0] kind, input logic [7:0] idx,
               input logic [7:0] val, input logic [6:0] leds);
        line_word_t p;
        send_item(kind, idx, val, leds, p);
        line_expect_q.push_back(p);
    endtask

    // drops s_tvalid and waits until the stream is drained
    task settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (line_expect_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        encoder_set_reg(idx, data);
    endtask

    task apply_timing(input timing_set_t t);
        // upper byte of the 8 bit registers is junk that must be dropped
        write_reg(CFG_ZERO_HIGH, {8'($urandom), t.zero_hi});
        write_reg(CFG_ONE_HIGH, {8'($urandom), t.one_hi});
        write_reg(CFG_BIT_PERIOD, {8'($urandom), t.period});
        write_reg(CFG_RESET_LOW, t.reset_lo);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task run_phase(input timing_set_t t, input int n_items);
        int                   i;
        int                   roll;
        logic [S_TUSER_W-1:0] k;
        logic [7:0]           a;
        logic [7:0]           v;
        logic [6:0]           c;
        for (i = 0; i < n_items; i++)
        begin
            roll = $urandom_range(99, 0);
            a = 8'($urandom);
            v = 8'($urandom);
            c = 7'($urandom_range(127, 0));
            if (enc_phase == PH_IDLE)
            begin
                if (roll < 55)
                begin
                    k = KIND_START;
                    c = 7'($urandom_range(t.leds_max, 1));
                end
                else if (roll < 60)
                begin
                    k = KIND_START;
                    c = 7'd0;
                end
                else if (roll < 80)
                    k = KIND_WRITE;
                else if (roll < 93)
                    k = KIND_TICK;
                else
                    k = KIND_SPARE;
            end
            else
            begin
                // mostly time steps, with writes and starts that must be dropped
                if (roll < 86)
                    k = KIND_TICK;
                else if (roll < 91)
                    k = KIND_WRITE;
                else if (roll < 96)
                    k = KIND_START;
                else
                    k = KIND_SPARE;
            end
            issue(k, a, v, c);
        end
        while (enc_phase != PH_IDLE)
            issue(KIND_TICK, 8'($urandom), 8'($urandom), 7'($urandom));
        settle();
    endtask

    stim_row_t   dir_rows [14];
    timing_set_t timing_sets [N_SETS];

    initial
    begin : stimulus
        int         r;
        int         j;
        int         s;
        line_word_t p;

        dir_rows = '{
            '{KIND_TICK,  8'h00, 8'h00, 7'h00, 16'd1,   1'b1, '{1'b0, 1'b1}},
            '{KIND_SPARE, 8'hFF, 8'hFF, 7'h7F, 16'd1,   1'b1, '{1'b0, 1'b1}},
            '{KIND_WRITE, 8'h00, 8'hFF, 7'h00, 16'd1,   1'b1, '{1'b0, 1'b1}},
            '{KIND_WRITE, 8'h01, 8'h00, 7'h7F, 16'd1,   1'b1, '{1'b0, 1'b1}},
            '{KIND_WRITE, 8'h02, 8'hA5, 7'h00, 16'd1,   1'b1, '{1'b0, 1'b1}},
            '{KIND_WRITE, 8'hFF, 8'h81, 7'h00, 16'd1,   1'b1, '{1'b0, 1'b1}},
            // zero leds: no frame
            '{KIND_START, 8'h00, 8'h00, 7'h00, 16'd1,   1'b1, '{1'b0, 1'b1}},
            '{KIND_START, 8'h00, 8'h00, 7'h01, 16'd1,   1'b1, '{1'b0, 1'b0}},
            // write and start while busy are dropped
            '{KIND_WRITE, 8'h00, 8'h00, 7'h00, 16'd1,   1'b1, '{1'b0, 1'b0}},
            '{KIND_START, 8'h00, 8'h00, 7'h7F, 16'd1,   1'b1, '{1'b0, 1'b0}},
            '{KIND_SPARE, 8'h00, 8'h00, 7'h00, 16'd1,   1'b1, '{1'b0, 1'b0}},
            // line held low for the whole reset time
            '{KIND_TICK,  8'h00, 8'h00, 7'h00, 16'd40,  1'b1, '{1'b0, 1'b0}},
            '{KIND_TICK,  8'h00, 8'h00, 7'h00, 16'd480, 1'b0, '{1'b0, 1'b0}},
            '{KIND_TICK,  8'h00, 8'h00, 7'h00, 16'd1,   1'b1, '{1'b0, 1'b1}}
        };

        timing_sets[0] = '{8'd1,   8'd3,   8'd4,   16'd6,  7'd1};
        timing_sets[1] = '{8'd1,   8'd1,   8'd2,   16'd1,  7'd2};
        // high time at or above the period
        timing_sets[2] = '{8'd255, 8'd255, 8'd3,   16'd3,  7'd1};
        timing_sets[3] = '{8'd2,   8'd5,   8'd6,   16'd5,  7'd1};
        timing_sets[4] = '{8'd12,  8'd2,   8'd5,   16'd20, 7'd1};
        // zero high time, zero period and zero reset time
        timing_sets[5] = '{8'd0,   8'd1,   8'd0,   16'd0,  7'd3};
        timing_sets[6] = '{8'd1,   8'd0,   8'd1,   16'd2,  7'd3};
        timing_sets[7] = '{8'd1,   8'd2,   8'd2,   16'd2,  7'd4};
        for (s = 8; s < N_SETS; s++)
            timing_sets[s] = '{8'($urandom_range(8, 1)), 8'($urandom_range(12, 1)),
                               8'($urandom_range(6, 2)), 16'($urandom_range(30, 1)),
                               7'd1};

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // short reset time keeps the directed frame brief
        write_reg(CFG_RESET_LOW, 16'd40);
        @(negedge clk);
        cfg_we <= 1'b0;

        set_idle_mode(3);
        for (r = 0; r < 14; r++)
        begin
            for (j = 0; j < dir_rows[r].reps; j++)
            begin
                send_item(dir_rows[r].kind, dir_rows[r].idx, dir_rows[r].val,
                          dir_rows[r].leds, p);
                line_expect_q.push_back(dir_rows[r].typed ? dir_rows[r].want : p);
            end
        end
        settle();

        for (s = 0; s < N_SETS; s++)
        begin
            set_idle_mode(s);
            apply_timing(timing_sets[s]);
            // every byte a frame can reach gets a value before it is read
            if (s == 0)
            begin
                for (j = 0; j < FILL_BYTES; j++)
                    issue(KIND_WRITE, 8'(j), 8'($urandom), 7'($urandom));
            end
            run_phase(timing_sets[s], PHASE_ITEMS);
        end

        err_count += line_expect_q.size();
        if (err_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
